FILE: src/wse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed SMA/EMA package
// Shared constants, configuration register codes, controller state type and
// the command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package wse_pkg;

    // Window store geometry (power-of-two depth, ring addressing by wrap).
    localparam int WIN_MAX    = 64;
    localparam int IDX_W      = $clog2(WIN_MAX);
    localparam int CNT_W      = $clog2(WIN_MAX + 1);

    // Sample, running sum and smoothing widths.
    localparam int SMP_W      = 32;
    localparam int SUM_W      = SMP_W + IDX_W;
    localparam int FRAC_W     = 16;
    localparam int ALPHA_W    = FRAC_W + 1;
    localparam int PROD_W     = SMP_W + ALPHA_W;
    localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ALPHA_W;

    localparam logic [CNT_W-1:0]   LEN_MAX     = CNT_W'(WIN_MAX);
    localparam logic [CNT_W-1:0]   LEN_RESET   = CNT_W'(WIN_MAX);
    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(1) << FRAC_W;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(13107);
    localparam logic [PROD_W-1:0]  ROUND_UP    = PROD_W'((1 << FRAC_W) - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIN_LEN = 1'b0,
        CFG_SMOOTH  = 1'b1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DROP_CHK,
        ST_DROP_SUB,
        ST_WRITE,
        ST_SEED_RD,
        ST_SEED,
        ST_DIFF,
        ST_MUL,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic accept;
        logic drop_sub;
        logic write;
        logic div_start;
        logic seed;
        logic age_dec;
        logic diff;
        logic mul;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic drop_more;
        logic age_zero;
        logic div_done;
        logic out_free;
    } t_sts;

endpackage

FILE: src/wse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/wse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed SMA/EMA controller
// Sequences the drop, store, EMA walk and result hand-off for each sample.
// ----------------------------------------------------------------------------
module wse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output wse_pkg::t_cmd o_cmd,
    input  wse_pkg::t_sts i_sts
);

    wse_pkg::t_state r_state;
    wse_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wse_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            wse_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = wse_pkg::ST_DROP_CHK;
                end
            end
            wse_pkg::ST_DROP_CHK: begin
                // The read of the candidate slot is issued in this cycle.
                if (i_sts.drop_more) begin
                    n_state = wse_pkg::ST_DROP_SUB;
                end else begin
                    n_state = wse_pkg::ST_WRITE;
                end
            end
            wse_pkg::ST_DROP_SUB: begin
                o_cmd.drop_sub = 1'b1;
                n_state        = wse_pkg::ST_DROP_CHK;
            end
            wse_pkg::ST_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = wse_pkg::ST_SEED_RD;
            end
            wse_pkg::ST_SEED_RD: begin
                o_cmd.div_start = 1'b1;
                n_state         = wse_pkg::ST_SEED;
            end
            wse_pkg::ST_SEED: begin
                o_cmd.seed = 1'b1;
                if (i_sts.age_zero) begin
                    n_state = wse_pkg::ST_FINISH;
                end else begin
                    o_cmd.age_dec = 1'b1;
                    n_state       = wse_pkg::ST_DIFF;
                end
            end
            wse_pkg::ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = wse_pkg::ST_MUL;
            end
            wse_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                if (i_sts.age_zero) begin
                    n_state = wse_pkg::ST_FINISH;
                end else begin
                    o_cmd.age_dec = 1'b1;
                    n_state       = wse_pkg::ST_DIFF;
                end
            end
            wse_pkg::ST_FINISH: begin
                if (i_sts.div_done && i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = wse_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wse_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/wse_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed SMA/EMA datapath
// Configuration registers, ring store, running sum, EMA step unit, serial
// divider and the output register.
// ----------------------------------------------------------------------------
module wse_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wse_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wse_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [wse_pkg::SMP_W-1:0]         i_sample,
    input  wse_pkg::t_cmd                     i_cmd,
    output wse_pkg::t_sts                     o_sts,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [wse_pkg::SMP_W-1:0]         o_simple_average,
    output logic [wse_pkg::SMP_W-1:0]         o_exponential_average,
    output logic [wse_pkg::CNT_W-1:0]         o_samples_held
);

    // Configuration and window bookkeeping (reset).
    logic [wse_pkg::CNT_W-1:0]     r_win_len,  n_win_len;
    logic [wse_pkg::ALPHA_W-1:0]   r_smooth,   n_smooth;
    logic [wse_pkg::IDX_W-1:0]     r_wi,       n_wi;
    logic [wse_pkg::CNT_W-1:0]     r_fill,     n_fill;
    logic [wse_pkg::SUM_W-1:0]     r_sum,      n_sum;
    logic                          r_dbusy,    n_dbusy;
    logic                          r_out_valid, n_out_valid;

    // Per-item working registers.
    logic [wse_pkg::SMP_W-1:0]     r_x,        n_x;
    logic [wse_pkg::CNT_W-1:0]     r_n,        n_n;
    logic [wse_pkg::CNT_W-1:0]     r_f,        n_f;
    logic [wse_pkg::ALPHA_W-1:0]   r_alpha,    n_alpha;
    logic [wse_pkg::CNT_W-1:0]     r_age,      n_age;
    logic [wse_pkg::SMP_W-1:0]     r_ema,      n_ema;
    logic [wse_pkg::SMP_W-1:0]     r_mag,      n_mag;
    logic                          r_neg,      n_neg;
    logic [wse_pkg::SUM_W-1:0]     r_dq,       n_dq;
    logic [wse_pkg::CNT_W-1:0]     r_rem,      n_rem;
    logic [wse_pkg::DIV_CNT_W-1:0] r_dcnt,     n_dcnt;
    logic [wse_pkg::SMP_W-1:0]     r_out_avg,  n_out_avg;
    logic [wse_pkg::SMP_W-1:0]     r_out_ema,  n_out_ema;
    logic [wse_pkg::CNT_W-1:0]     r_out_held, n_out_held;

    // Combinational helpers.
    logic [wse_pkg::CNT_W-1:0]     len_eff;
    logic [wse_pkg::CNT_W-1:0]     fill_p1;
    logic [wse_pkg::CNT_W-1:0]     n_calc;
    logic [wse_pkg::ALPHA_W-1:0]   alpha_eff;
    logic [wse_pkg::CNT_W-1:0]     rd_age;
    logic [wse_pkg::IDX_W-1:0]     rd_addr;
    logic [wse_pkg::SMP_W-1:0]     rd_data;
    logic [wse_pkg::PROD_W-1:0]    prod;
    logic [wse_pkg::SMP_W-1:0]     step;
    logic [wse_pkg::CNT_W:0]       trial;
    logic                          trial_ge;

    // Effective window length, held count and clamped smoothing factor.
    always_comb begin
        if (r_win_len == '0) begin
            len_eff = wse_pkg::CNT_W'(1);
        end else if (r_win_len > wse_pkg::LEN_MAX) begin
            len_eff = wse_pkg::LEN_MAX;
        end else begin
            len_eff = r_win_len;
        end
        fill_p1   = r_fill + wse_pkg::CNT_W'(1);
        n_calc    = (fill_p1 < len_eff) ? fill_p1 : len_eff;
        alpha_eff = (r_smooth > wse_pkg::ALPHA_ONE) ? wse_pkg::ALPHA_ONE : r_smooth;
    end

    // Ring address of the sample of a given age; age zero is the write slot.
    assign rd_age  = i_cmd.age_dec ? (r_age - wse_pkg::CNT_W'(1)) : r_age;
    assign rd_addr = r_wi - rd_age[wse_pkg::IDX_W-1:0];

    wse_ram #(
        .WIDTH (wse_pkg::SMP_W),
        .DEPTH (wse_pkg::WIN_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_wi),
        .i_wdata (r_x),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // EMA step: scaled magnitude, rounded up when falling so the new value rounds down.
    assign prod = (wse_pkg::PROD_W'(r_mag) * wse_pkg::PROD_W'(r_alpha))
                  + (r_neg ? wse_pkg::ROUND_UP : '0);
    assign step = prod[wse_pkg::FRAC_W +: wse_pkg::SMP_W];

    // One restoring division step of the running sum by the held count.
    assign trial    = {r_rem, r_dq[wse_pkg::SUM_W-1]};
    assign trial_ge = (trial >= {1'b0, r_n});

    // Next-state logic for every register.
    always_comb begin
        n_win_len   = r_win_len;
        n_smooth    = r_smooth;
        n_wi        = r_wi;
        n_fill      = r_fill;
        n_sum       = r_sum;
        n_dbusy     = r_dbusy;
        n_out_valid = r_out_valid;
        n_x         = r_x;
        n_n         = r_n;
        n_f         = r_f;
        n_alpha     = r_alpha;
        n_age       = r_age;
        n_ema       = r_ema;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_dq        = r_dq;
        n_rem       = r_rem;
        n_dcnt      = r_dcnt;
        n_out_avg   = r_out_avg;
        n_out_ema   = r_out_ema;
        n_out_held  = r_out_held;

        // Register writes.
        if (i_cfg_we) begin
            case (wse_pkg::t_cfg_idx'(i_cfg_idx))
                wse_pkg::CFG_WIN_LEN: n_win_len = i_cfg_data[wse_pkg::CNT_W-1:0];
                wse_pkg::CFG_SMOOTH:  n_smooth  = i_cfg_data[wse_pkg::ALPHA_W-1:0];
                default: ;
            endcase
        end

        // Item set-up on acceptance.
        if (i_cmd.accept) begin
            n_x     = i_sample;
            n_n     = n_calc;
            n_f     = r_fill;
            n_alpha = alpha_eff;
            n_age   = n_calc;
        end

        // Remove samples that have left the window.
        if (i_cmd.drop_sub) begin
            n_sum = r_sum - wse_pkg::SUM_W'(rd_data);
            n_age = r_age + wse_pkg::CNT_W'(1);
        end

        // Store the new sample and seed the walk at the oldest held age.
        if (i_cmd.write) begin
            n_sum  = r_sum + wse_pkg::SUM_W'(r_x);
            n_fill = r_n;
            n_age  = r_n - wse_pkg::CNT_W'(1);
        end

        if (i_cmd.age_dec) begin
            n_age = rd_age;
        end

        if (i_cmd.seed) begin
            n_ema = rd_data;
        end

        if (i_cmd.diff) begin
            if (rd_data >= r_ema) begin
                n_mag = rd_data - r_ema;
                n_neg = 1'b0;
            end else begin
                n_mag = r_ema - rd_data;
                n_neg = 1'b1;
            end
        end

        if (i_cmd.mul) begin
            n_ema = r_neg ? (r_ema - step) : (r_ema + step);
        end

        // Serial divider.
        if (i_cmd.div_start) begin
            n_dq    = r_sum;
            n_rem   = '0;
            n_dcnt  = wse_pkg::DIV_CNT_W'(wse_pkg::SUM_W);
            n_dbusy = 1'b1;
        end else if (r_dbusy) begin
            n_dq    = {r_dq[wse_pkg::SUM_W-2:0], trial_ge};
            n_rem   = trial_ge ? (trial[wse_pkg::CNT_W-1:0] - r_n)
                               : trial[wse_pkg::CNT_W-1:0];
            n_dcnt  = r_dcnt - wse_pkg::DIV_CNT_W'(1);
            n_dbusy = (r_dcnt != wse_pkg::DIV_CNT_W'(1));
        end

        // Output register.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.finish) begin
            n_out_valid = 1'b1;
            n_out_avg   = r_dq[wse_pkg::SMP_W-1:0];
            n_out_ema   = r_ema;
            n_out_held  = r_n;
            n_wi        = r_wi + wse_pkg::IDX_W'(1);
        end
    end

    // Control and bookkeeping registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= wse_pkg::LEN_RESET;
            r_smooth    <= wse_pkg::ALPHA_RESET;
            r_wi        <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_dbusy     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_win_len   <= n_win_len;
            r_smooth    <= n_smooth;
            r_wi        <= n_wi;
            r_fill      <= n_fill;
            r_sum       <= n_sum;
            r_dbusy     <= n_dbusy;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_x        <= n_x;
        r_n        <= n_n;
        r_f        <= n_f;
        r_alpha    <= n_alpha;
        r_age      <= n_age;
        r_ema      <= n_ema;
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_dq       <= n_dq;
        r_rem      <= n_rem;
        r_dcnt     <= n_dcnt;
        r_out_avg  <= n_out_avg;
        r_out_ema  <= n_out_ema;
        r_out_held <= n_out_held;
    end

    // Status to the controller.
    assign o_sts.drop_more = (r_age <= r_f);
    assign o_sts.age_zero  = (r_age == '0);
    assign o_sts.div_done  = !r_dbusy;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid           = r_out_valid;
    assign o_simple_average      = r_out_avg;
    assign o_exponential_average = r_out_ema;
    assign o_samples_held        = r_out_held;

endmodule

FILE: src/windowed_sma_ema_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Windowed SMA/EMA top level
// One Q16.16 sample in, one simple and one exponential average out.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one sample on i_sample (i_in_valid / o_in_ready).
//   Result beats carry the truncated mean, the EMA and the held count
//   (o_out_valid / i_out_ready). One result beat follows every input beat.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   the block is idle: index 0 is the window length, index 1 the smoothing.
//   Samples are processed one at a time. Each input beat first drops the
//   samples that have left the window and stores the new one; the result is
//   then ready once the EMA walk, which reads each held sample in turn
//   through the single read port of the window store, and the 38-step
//   serial divider running alongside it are both done.
//   o_in_ready rises again as soon as a result is in the output register, so
//   the next sample can be taken while that result waits. A stalled receiver
//   holds the result and stalls the following one in its final cycle.
//   Reset empties the window, zeroes the running sum and restores the window
//   length to 64 and the smoothing to 13107; no clearing pass is needed.
// ----------------------------------------------------------------------------
module windowed_sma_ema_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [wse_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wse_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [wse_pkg::SMP_W-1:0]      i_sample,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [wse_pkg::SMP_W-1:0]      o_simple_average,
    output logic [wse_pkg::SMP_W-1:0]      o_exponential_average,
    output logic [wse_pkg::CNT_W-1:0]      o_samples_held
);

    wse_pkg::t_cmd cmd;
    wse_pkg::t_sts sts;

    // Sequencer.
    wse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // Arithmetic, store and result register.
    wse_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_idx             (i_cfg_idx),
        .i_cfg_data            (i_cfg_data),
        .i_sample              (i_sample),
        .i_cmd                 (cmd),
        .o_sts                 (sts),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_simple_average      (o_simple_average),
        .o_exponential_average (o_exponential_average),
        .o_samples_held        (o_samples_held)
    );

`ifndef SYNTH
    // Once a sample is taken, no further sample is taken until it is done.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while an item is in progress");

    // A presented result always reports a held count inside the window.
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_samples_held != '0 &&
                         o_samples_held <= wse_pkg::CNT_W'(wse_pkg::WIN_MAX)))
        else $error("held sample count out of range");

    // A new result appears only at the end of an item's work.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without an item in progress");
`endif

endmodule
